/* src/cbb_pkg.sv */
// Shared types, register-file addresses and micro-op programs of the Bezier box unit.
// No dependencies; used by cbb_ctrl, cbb_dp and the top level.
package cbb_pkg;

  // Width of every internal curve value: a 32-bit coordinate and its differences fit.
  localparam int DW = 34;

  typedef logic [3:0] addr_t;

  // Operand space: the four points of the current axis, then scratch registers.
  localparam addr_t A_P0 = 4'd0;
  localparam addr_t A_P1 = 4'd1;
  localparam addr_t A_P2 = 4'd2;
  localparam addr_t A_P3 = 4'd3;
  localparam addr_t A_D0 = 4'd4;
  localparam addr_t A_D1 = 4'd5;
  localparam addr_t A_D2 = 4'd6;
  localparam addr_t A_T0 = 4'd7;
  localparam addr_t A_T1 = 4'd8;
  localparam addr_t A_T2 = 4'd9;
  localparam addr_t A_T3 = 4'd10;
  localparam addr_t A_T4 = 4'd11;
  localparam addr_t A_S  = 4'd12;

  typedef enum logic {
    OP_SUB  = 1'b0,
    OP_LERP = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    TS_HALF = 2'd0,
    TS_MID  = 2'd1,
    TS_LO   = 2'd2
  } tsel_t;

  typedef enum logic [1:0] {
    PRG_PREP  = 2'd0,
    PRG_DERIV = 2'd1,
    PRG_VALUE = 2'd2
  } prog_t;

  typedef struct packed {
    op_t   op;
    addr_t ra;
    addr_t rb;
    addr_t wd;
    tsel_t tsel;
  } uop_t;

  typedef struct packed {
    logic       capture;
    logic       init_axis;
    logic       op_valid;
    uop_t       uop;
    logic       start;
    logic       hsel;
    logic       bis_step;
    logic       widen;
    logic       load_out;
    logic       axis;
  } cmd_t;

  typedef struct packed {
    logic op_done;
    logic span_one;
    logic need_h0;
    logic need_h1;
    logic s1_zero;
  } sts_t;

  function automatic uop_t mk(op_t op, addr_t ra, addr_t rb, addr_t wd, tsel_t ts);
    uop_t u;
    u.op   = op;
    u.ra   = ra;
    u.rb   = rb;
    u.wd   = wd;
    u.tsel = ts;
    return u;
  endfunction

  function automatic logic [2:0] prog_last(prog_t p);
    logic [2:0] n;
    unique case (p)
      PRG_DERIV: n = 3'd2;
      default:   n = 3'd5;
    endcase
    return n;
  endfunction

  // Micro-op programs: differences plus derivative at one half, derivative at mid,
  // and the de Casteljau value at lo.
  function automatic uop_t uop_rom(prog_t p, logic [2:0] idx);
    uop_t u;
    u = mk(OP_LERP, A_T0, A_T1, A_S, TS_LO);
    unique case (p)
      PRG_PREP: begin
        unique case (idx)
          3'd0:    u = mk(OP_SUB,  A_P0, A_P1, A_D0, TS_HALF);
          3'd1:    u = mk(OP_SUB,  A_P1, A_P2, A_D1, TS_HALF);
          3'd2:    u = mk(OP_SUB,  A_P2, A_P3, A_D2, TS_HALF);
          3'd3:    u = mk(OP_LERP, A_D0, A_D1, A_T0, TS_HALF);
          3'd4:    u = mk(OP_LERP, A_D1, A_D2, A_T1, TS_HALF);
          default: u = mk(OP_LERP, A_T0, A_T1, A_S,  TS_HALF);
        endcase
      end
      PRG_DERIV: begin
        unique case (idx)
          3'd0:    u = mk(OP_LERP, A_D0, A_D1, A_T0, TS_MID);
          3'd1:    u = mk(OP_LERP, A_D1, A_D2, A_T1, TS_MID);
          default: u = mk(OP_LERP, A_T0, A_T1, A_S,  TS_MID);
        endcase
      end
      default: begin
        unique case (idx)
          3'd0:    u = mk(OP_LERP, A_P0, A_P1, A_T0, TS_LO);
          3'd1:    u = mk(OP_LERP, A_P1, A_P2, A_T1, TS_LO);
          3'd2:    u = mk(OP_LERP, A_P2, A_P3, A_T2, TS_LO);
          3'd3:    u = mk(OP_LERP, A_T0, A_T1, A_T3, TS_LO);
          3'd4:    u = mk(OP_LERP, A_T1, A_T2, A_T4, TS_LO);
          default: u = mk(OP_LERP, A_T3, A_T4, A_S,  TS_LO);
        endcase
      end
    endcase
    return u;
  endfunction

endpackage

/* src/cbb_ctrl.sv */
// Sequencer of the Bezier box unit: runs micro-op programs and the bisection per axis.
// Depends on cbb_pkg.
module cbb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output cbb_pkg::cmd_t cmd,
  input  cbb_pkg::sts_t sts
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_INIT  = 9'b000000010,
    S_PROG  = 9'b000000100,
    S_SPLIT = 9'b000001000,
    S_BSTEP = 9'b000010000,
    S_BCHK  = 9'b000100000,
    S_WIDEN = 9'b001000000,
    S_AXEND = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    PH_H0  = 2'd0,
    PH_H1  = 2'd1,
    PH_MID = 2'd2
  } phase_t;

  state_t          state, state_next, ret, ret_next;
  phase_t          phase, phase_next;
  cbb_pkg::prog_t  prog, prog_next;
  logic [2:0]      cnt, cnt_next;
  logic            issued, issued_next;
  logic            axis, axis_next;
  logic            out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    ret_next       = ret;
    phase_next     = phase;
    prog_next      = prog;
    cnt_next       = cnt;
    issued_next    = issued;
    axis_next      = axis;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.uop        = cbb_pkg::uop_rom(prog, cnt);
    cmd.axis       = axis;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          axis_next   = 1'b0;
          state_next  = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init_axis = 1'b1;
        prog_next     = cbb_pkg::PRG_PREP;
        cnt_next      = '0;
        ret_next      = S_SPLIT;
        phase_next    = PH_H0;
        state_next    = S_PROG;
      end
      S_PROG: begin
        if (!issued) begin
          cmd.op_valid = 1'b1;
          issued_next  = 1'b1;
        end else if (sts.op_done) begin
          issued_next = 1'b0;
          if (cnt == cbb_pkg::prog_last(prog)) begin
            cnt_next   = '0;
            state_next = ret;
          end else begin
            cnt_next = cnt + 3'd1;
          end
        end
      end
      S_SPLIT: begin
        unique case (phase)
          PH_H0: begin
            if (sts.need_h0) begin
              cmd.start  = 1'b1;
              cmd.hsel   = 1'b0;
              prog_next  = cbb_pkg::PRG_DERIV;
              ret_next   = S_BSTEP;
              state_next = S_PROG;
            end else begin
              phase_next = PH_H1;
            end
          end
          PH_H1: begin
            if (sts.need_h1) begin
              cmd.start  = 1'b1;
              cmd.hsel   = 1'b1;
              prog_next  = cbb_pkg::PRG_DERIV;
              ret_next   = S_BSTEP;
              state_next = S_PROG;
            end else begin
              phase_next = PH_MID;
            end
          end
          default: begin
            if (sts.s1_zero) begin
              // lo lands on one half: the value program then evaluates the midpoint
              cmd.start  = 1'b1;
              cmd.hsel   = 1'b1;
              prog_next  = cbb_pkg::PRG_VALUE;
              ret_next   = S_WIDEN;
              state_next = S_PROG;
            end else begin
              state_next = S_AXEND;
            end
          end
        endcase
      end
      S_BSTEP: begin
        cmd.bis_step = 1'b1;
        state_next   = S_BCHK;
      end
      S_BCHK: begin
        if (sts.span_one) begin
          prog_next = cbb_pkg::PRG_VALUE;
          ret_next  = S_WIDEN;
        end else begin
          prog_next = cbb_pkg::PRG_DERIV;
          ret_next  = S_BSTEP;
        end
        state_next = S_PROG;
      end
      S_WIDEN: begin
        cmd.widen = 1'b1;
        unique case (phase)
          PH_H0: begin
            phase_next = PH_H1;
            state_next = S_SPLIT;
          end
          PH_H1: begin
            phase_next = PH_MID;
            state_next = S_SPLIT;
          end
          default: state_next = S_AXEND;
        endcase
      end
      S_AXEND: begin
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = S_INIT;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      phase     <= PH_H0;
      prog      <= cbb_pkg::PRG_PREP;
      cnt       <= '0;
      issued    <= 1'b0;
      axis      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ret       <= ret_next;
      phase     <= phase_next;
      prog      <= prog_next;
      cnt       <= cnt_next;
      issued    <= issued_next;
      axis      <= axis_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* src/cbb_dp.sv */
// Datapath of the Bezier box unit: point registers, scratch memory, shared lerp unit,
// bisection interval and box registers. Depends on cbb_pkg.
module cbb_dp #(
  parameter int T_FRAC_BITS = 24,
  parameter int COORD_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cbb_pkg::cmd_t                cmd,
  output cbb_pkg::sts_t                sts,
  input  logic [31:0]                  start_x,
  input  logic [31:0]                  start_y,
  input  logic [31:0]                  ctrl1_x,
  input  logic [31:0]                  ctrl1_y,
  input  logic [31:0]                  ctrl2_x,
  input  logic [31:0]                  ctrl2_y,
  input  logic [31:0]                  end_x,
  input  logic [31:0]                  end_y,
  output logic signed [cbb_pkg::DW-1:0] box_min_x,
  output logic signed [cbb_pkg::DW-1:0] box_min_y,
  output logic signed [cbb_pkg::DW-1:0] box_max_x,
  output logic signed [cbb_pkg::DW-1:0] box_max_y
);

  localparam int DW = cbb_pkg::DW;
  localparam int CW = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int TW = T_FRAC_BITS + 1;
  localparam int PW = DW + 1 + TW + 1;
  localparam logic [TW-1:0] T_HALF = TW'(1) << (T_FRAC_BITS - 1);
  localparam logic [TW-1:0] T_ONE  = TW'(1) << T_FRAC_BITS;

  logic signed [DW-1:0] px [4];
  logic signed [DW-1:0] py [4];
  logic signed [DW-1:0] mem [16];
  logic signed [DW-1:0] rd_a, rd_b, a_r, last;
  logic signed [DW:0]   diff_r;
  logic signed [PW-1:0] prod_r, prod_sh;
  logic signed [DW-1:0] res;
  logic [3:0]           v;
  cbb_pkg::uop_t        u_r;
  logic [TW-1:0]        lo, hi, mid, t_cur;
  logic [1:0]           s0, s1, s2, slo; // {negative, positive}
  logic                 last_neg, last_pos;

  function automatic logic signed [DW-1:0] sx(logic [31:0] f);
    return DW'(signed'(f[CW-1:0]));
  endfunction

  function automatic logic opp(logic [1:0] a, logic [1:0] b);
    return (a[1] && b[0]) || (a[0] && b[1]);
  endfunction

  // Point of the current axis at a fixed operand address
  function automatic logic signed [DW-1:0] pt(logic ax, logic [1:0] i,
                                              logic signed [DW-1:0] qx [4],
                                              logic signed [DW-1:0] qy [4]);
    return ax ? qy[i] : qx[i];
  endfunction

  assign mid = lo + ((hi - lo) >> 1);

  always_comb begin
    unique case (u_r.tsel)
      cbb_pkg::TS_HALF: t_cur = T_HALF;
      cbb_pkg::TS_MID:  t_cur = mid;
      cbb_pkg::TS_LO:   t_cur = lo;
      default:          t_cur = lo;
    endcase
  end

  assign prod_sh  = prod_r >>> T_FRAC_BITS;
  assign res      = (u_r.op == cbb_pkg::OP_SUB) ? diff_r[DW-1:0] : a_r + prod_sh[DW-1:0];
  assign last_neg = last[DW-1];
  assign last_pos = !last[DW-1] && (last != '0);

  assign sts.op_done  = v[3];
  assign sts.span_one = (hi - lo) <= TW'(1);
  assign sts.need_h0  = opp(s0, s1);
  assign sts.need_h1  = opp(s1, s2);
  assign sts.s1_zero  = (s1 == 2'b00);

  // Operand read and lerp pipeline: read, subtract, multiply, write back
  always_ff @(posedge clk) begin
    if (cmd.op_valid) begin
      u_r <= cmd.uop;
    end
    if (cmd.op_valid) begin
      if (cmd.uop.ra < cbb_pkg::A_D0) rd_a <= pt(cmd.axis, cmd.uop.ra[1:0], px, py);
      else                             rd_a <= mem[cmd.uop.ra];
      if (cmd.uop.rb < cbb_pkg::A_D0) rd_b <= pt(cmd.axis, cmd.uop.rb[1:0], px, py);
      else                             rd_b <= mem[cmd.uop.rb];
    end
    if (v[0]) begin
      diff_r <= (DW+1)'(rd_b) - (DW+1)'(rd_a);
      a_r    <= rd_a;
    end
    if (v[1]) begin
      prod_r <= diff_r * signed'({1'b0, t_cur});
    end
    if (v[2]) begin
      mem[u_r.wd] <= res;
      last        <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[2:0], cmd.op_valid};
    end
  end

  // Capture points, derivative signs, bisection interval and box
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px[0] <= sx(start_x);
      px[1] <= sx(ctrl1_x);
      px[2] <= sx(ctrl2_x);
      px[3] <= sx(end_x);
      py[0] <= sx(start_y);
      py[1] <= sx(ctrl1_y);
      py[2] <= sx(ctrl2_y);
      py[3] <= sx(end_y);
    end
    if (v[2]) begin
      if (u_r.wd == cbb_pkg::A_D0) s0 <= {res[DW-1], !res[DW-1] && (res != '0)};
      if (u_r.wd == cbb_pkg::A_D2) s2 <= {res[DW-1], !res[DW-1] && (res != '0)};
      if (u_r.wd == cbb_pkg::A_S && u_r.tsel == cbb_pkg::TS_HALF) begin
        s1 <= {res[DW-1], !res[DW-1] && (res != '0)};
      end
    end
    if (cmd.start) begin
      lo  <= cmd.hsel ? T_HALF : '0;
      hi  <= cmd.hsel ? T_ONE : T_HALF;
      slo <= cmd.hsel ? s1 : s0;
    end
    if (cmd.bis_step) begin
      priority if (!last_neg && !last_pos) begin
        // exact root: collapse the interval onto mid
        lo <= mid;
        hi <= mid + TW'(1);
      end else if ((slo[1] && last_neg) || (slo[0] && last_pos)) begin
        lo <= mid;
      end else begin
        hi <= mid;
      end
    end
    if (cmd.init_axis) begin
      if (!cmd.axis) begin
        box_min_x <= (px[0] < px[3]) ? px[0] : px[3];
        box_max_x <= (px[0] < px[3]) ? px[3] : px[0];
      end else begin
        box_min_y <= (py[0] < py[3]) ? py[0] : py[3];
        box_max_y <= (py[0] < py[3]) ? py[3] : py[0];
      end
    end
    if (cmd.widen) begin
      if (!cmd.axis) begin
        if (last < box_min_x) box_min_x <= last;
        if (last > box_max_x) box_max_x <= last;
      end else begin
        if (last < box_min_y) box_min_y <= last;
        if (last > box_max_y) box_max_y <= last;
      end
    end
  end

endmodule

/* src/cubic_bezier_bounding_box.sv */
// Cubic Bezier bounding box engine: top level with output word register and assertions.
// Depends on cbb_pkg, cbb_ctrl and cbb_dp.

// Takes one word of four Q16.16 control points and returns one word holding the
// axis-aligned box of the curve. Each axis in turn: the box starts at the end points,
// the derivative sign is taken at t = 0, 1/2 and 1, and in each half whose end signs
// strictly differ a bisection over a T_FRAC_BITS-bit t finds the turning point, whose
// curve value widens the box; a zero derivative at one half adds the midpoint value.
// Everything runs on one shared lerp unit (operand read, subtract, multiply, write
// back), which takes one operation at a time. Per axis: a setup program, then for each
// searched half about T_FRAC_BITS bisection steps (three lerps and an update each)
// plus a value program for the curve value, plus one more value program for a flat
// midpoint. One item is processed at a time; the finished box waits in an output
// register, so a new word is taken while the previous box waits.
module cubic_bezier_bounding_box #(
  parameter int T_FRAC_BITS = 24,
  parameter int COORD_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] start_x,
  input  logic [31:0] start_y,
  input  logic [31:0] ctrl1_x,
  input  logic [31:0] ctrl1_y,
  input  logic [31:0] ctrl2_x,
  input  logic [31:0] ctrl2_y,
  input  logic [31:0] end_x,
  input  logic [31:0] end_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] min_x,
  output logic [31:0] min_y,
  output logic [31:0] max_x,
  output logic [31:0] max_y
);

  cbb_pkg::cmd_t                 cmd;
  cbb_pkg::sts_t                 sts;
  logic signed [cbb_pkg::DW-1:0] box_min_x, box_min_y, box_max_x, box_max_y;

  cbb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  cbb_dp #(
    .T_FRAC_BITS (T_FRAC_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .start_x   (start_x),
    .start_y   (start_y),
    .ctrl1_x   (ctrl1_x),
    .ctrl1_y   (ctrl1_y),
    .ctrl2_x   (ctrl2_x),
    .ctrl2_y   (ctrl2_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .box_min_x (box_min_x),
    .box_min_y (box_min_y),
    .box_max_x (box_max_x),
    .box_max_y (box_max_y)
  );

  // Hold the finished box until it is taken; every curve value stays in 32 bits
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      min_x <= box_min_x[31:0];
      min_y <= box_min_y[31:0];
      max_x <= box_max_x[31:0];
      max_y <= box_max_y[31:0];
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again while an item is in progress");

  a_box_x_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(min_x) <= $signed(max_x)))
    else $error("x extent inverted");

  a_box_y_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(min_y) <= $signed(max_y)))
    else $error("y extent inverted");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("pending box overwritten");
`endif

endmodule

/* bench/cbb_box_checker.sv */
// Checker for the Bezier box unit: watches both channels, predicts each box, compares.
// No package dependency; instantiated beside the unit by tb_cubic_bezier_bounding_box.
`timescale 1ns / 100ps

module cbb_box_checker #(
  parameter int T_FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] start_x,
  input  logic [31:0] start_y,
  input  logic [31:0] ctrl1_x,
  input  logic [31:0] ctrl1_y,
  input  logic [31:0] ctrl2_x,
  input  logic [31:0] ctrl2_y,
  input  logic [31:0] end_x,
  input  logic [31:0] end_y,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] min_x,
  input  logic [31:0] min_y,
  input  logic [31:0] max_x,
  input  logic [31:0] max_y,
  output int          errors,
  output int          boxes_checked,
  output int          boxes_pending
);

  typedef struct packed {
    logic [31:0] mn_x;
    logic [31:0] mn_y;
    logic [31:0] mx_x;
    logic [31:0] mx_y;
  } box_t;

  localparam longint T_ONE = longint'(1) << T_FRAC_BITS;

  box_t boxes_due[$];

  // floor(x * t / 2^T_FRAC_BITS) with an exact wide product
  function automatic longint scale_by_t(longint x, longint t);
    logic signed [127:0] xs, ts, prod;
    xs = x;
    ts = t;
    prod = xs * ts;
    prod = prod >>> T_FRAC_BITS;
    return longint'(prod[63:0]);
  endfunction

  function automatic longint blend(longint a, longint b, longint t);
    return a + scale_by_t(b - a, t);
  endfunction

  function automatic longint slope_at(longint d[3], longint t);
    return blend(blend(d[0], d[1], t), blend(d[1], d[2], t), t);
  endfunction

  function automatic longint curve_at(longint p[4], longint t);
    longint a, b, c;
    a = blend(p[0], p[1], t);
    b = blend(p[1], p[2], t);
    c = blend(p[2], p[3], t);
    return blend(blend(a, b, t), blend(b, c, t), t);
  endfunction

  function automatic bit signs_differ(longint a, longint b);
    return (a < 0 && b > 0) || (a > 0 && b < 0);
  endfunction

  // Narrow [lo,hi] down to the turning point; the slope sign at lo is known.
  function automatic longint find_turn(longint d[3], longint lo, longint hi, longint slo);
    longint mid, s;
    while (hi - lo > 1) begin
      mid = lo + ((hi - lo) >> 1);
      s = slope_at(d, mid);
      if (s == 0) return mid;
      if ((slo < 0 && s < 0) || (slo > 0 && s > 0)) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic void axis_range(longint p[4], output longint mn, output longint mx);
    longint d[3];
    longint s0, s1, s2, v;
    mn = (p[0] < p[3]) ? p[0] : p[3];
    mx = (p[0] < p[3]) ? p[3] : p[0];
    d[0] = p[1] - p[0];
    d[1] = p[2] - p[1];
    d[2] = p[3] - p[2];
    s0 = d[0];
    s1 = slope_at(d, T_ONE >> 1);
    s2 = d[2];
    if (signs_differ(s0, s1)) begin
      v = curve_at(p, find_turn(d, 0, T_ONE >> 1, s0));
      if (v < mn) mn = v;
      if (v > mx) mx = v;
    end
    if (signs_differ(s1, s2)) begin
      v = curve_at(p, find_turn(d, T_ONE >> 1, T_ONE, s1));
      if (v < mn) mn = v;
      if (v > mx) mx = v;
    end
    if (s1 == 0) begin
      v = curve_at(p, T_ONE >> 1);
      if (v < mn) mn = v;
      if (v > mx) mx = v;
    end
  endfunction

  function automatic box_t predict_box();
    longint px[4], py[4];
    longint lo, hi;
    box_t b;
    px[0] = longint'(signed'(start_x)); py[0] = longint'(signed'(start_y));
    px[1] = longint'(signed'(ctrl1_x)); py[1] = longint'(signed'(ctrl1_y));
    px[2] = longint'(signed'(ctrl2_x)); py[2] = longint'(signed'(ctrl2_y));
    px[3] = longint'(signed'(end_x));   py[3] = longint'(signed'(end_y));
    axis_range(px, lo, hi);
    b.mn_x = lo[31:0];
    b.mx_x = hi[31:0];
    axis_range(py, lo, hi);
    b.mn_y = lo[31:0];
    b.mx_y = hi[31:0];
    return b;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name,
               signed'(want), signed'(got));
      errors++;
    end
  endfunction

  assign boxes_pending = boxes_due.size();

  initial begin
    errors = 0;
    boxes_checked = 0;
  end

  always @(posedge clk) begin
    box_t want;
    if (!rst) begin
      if (in_valid && in_ready) boxes_due.push_back(predict_box());
      if (out_valid && out_ready) begin
        if (boxes_due.size() == 0) begin
          $display("%0t: box word with none expected: %0d %0d %0d %0d", $time,
                   signed'(min_x), signed'(min_y), signed'(max_x), signed'(max_y));
          errors++;
        end else begin
          want = boxes_due.pop_front();
          compare_field("min_x", want.mn_x, min_x);
          compare_field("min_y", want.mn_y, min_y);
          compare_field("max_x", want.mx_x, max_x);
          compare_field("max_y", want.mx_y, max_y);
          boxes_checked++;
        end
      end
    end
  end

endmodule

/* bench/tb_cubic_bezier_bounding_box.sv */
// Testbench top for cubic_bezier_bounding_box: drives control-point words, stalls the box side.
// Depends on the unit under test and cbb_box_checker, which predicts and compares.
`timescale 1ns / 100ps

module tb_cubic_bezier_bounding_box;

  localparam int N_RANDOM    = 1530;
  localparam int CALM_TAIL   = 150;    // last words go with no idling on either side
  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] start_x = '0, start_y = '0, ctrl1_x = '0, ctrl1_y = '0;
  logic [31:0] ctrl2_x = '0, ctrl2_y = '0, end_x = '0, end_y = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] min_x, min_y, max_x, max_y;

  int errors, boxes_checked, boxes_pending;
  int words_sent = 0;
  bit calm = 1'b0;
  int idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cubic_bezier_bounding_box dut (
    .clk, .rst, .in_valid, .in_ready,
    .start_x, .start_y, .ctrl1_x, .ctrl1_y, .ctrl2_x, .ctrl2_y, .end_x, .end_y,
    .out_valid, .out_ready, .min_x, .min_y, .max_x, .max_y
  );

  cbb_box_checker checker_i (
    .clk, .rst, .in_valid, .in_ready,
    .start_x, .start_y, .ctrl1_x, .ctrl1_y, .ctrl2_x, .ctrl2_y, .end_x, .end_y,
    .out_valid, .out_ready, .min_x, .min_y, .max_x, .max_y,
    .errors, .boxes_checked, .boxes_pending
  );

  // Box side: stall at random, none once the run is calm.
  always @(negedge clk) begin
    if (rst || calm) begin
      out_ready <= ~rst;
      idle_cycles <= 0;
    end else if (idle_cycles > 0) begin
      out_ready <= 1'b0;
      idle_cycles <= idle_cycles - 1;
    end else if ($urandom_range(3) == 0) begin
      out_ready <= 1'b0;
      idle_cycles <= $urandom_range(7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: count cycles in which neither channel moves a word.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Present one word at the falling edge and hold it until accepted.
  task automatic send_curve(logic [31:0] x0, logic [31:0] y0, logic [31:0] x1,
                            logic [31:0] y1, logic [31:0] x2, logic [31:0] y2,
                            logic [31:0] x3, logic [31:0] y3);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(4) == 0) gap = $urandom_range(1, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    start_x = x0; start_y = y0; ctrl1_x = x1; ctrl1_y = y1;
    ctrl2_x = x2; ctrl2_y = y2; end_x = x3; end_y = y3;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // One random coordinate: full range, clustered near a base so that curves turn, or a field extreme.
  function automatic logic [31:0] pick_coord(int style, logic [31:0] base);
    case (style)
      0: return $urandom;
      1: return base + ($urandom & ((32'd1 << $urandom_range(4, 30)) - 1))
                - (32'd1 << 3);
      default: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  initial begin
    logic [31:0] base, c[8];
    int style;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes, plain lines, turning points in each half,
    // a flat midpoint, a zero slope at an end point, two turns in one half.
    send_curve(0, 0, 0, 0, 0, 0, 0, 0);
    send_curve('1, '1, '1, '1, '1, '1, '1, '1);
    send_curve(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_curve(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_curve(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_curve(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_curve(32'h0001_0000, 32'h0002_0000, 32'h0002_0000, 32'h0004_0000,
               32'h0003_0000, 32'h0006_0000, 32'h0004_0000, 32'h0008_0000);
    // overshoot early (first half) and late (second half)
    send_curve(0, 0, 32'h0064_0000, 32'h0010_0000, 32'h0005_0000, 32'hFF9C_0000,
               32'h000A_0000, 32'h0001_0000);
    send_curve(0, 0, 32'hFFFB_0000, 32'h0005_0000, 32'hFF9C_0000, 32'h0064_0000,
               32'h000A_0000, 32'h000A_0000);
    // symmetric hump: slope exactly zero at the middle
    send_curve(0, 0, 32'h0010_0000, 32'hFFF0_0000, 32'h0010_0000, 32'hFFF0_0000, 0, 0);
    send_curve(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    // zero slope at an end point
    send_curve(32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000,
               32'h0020_0000, 32'hFFE0_0000, 32'h0001_0000, 32'h0009_0000);
    send_curve(0, 0, 32'h0020_0000, 32'hFFE0_0000, 32'h0030_0000, 32'h0030_0000,
               32'h0030_0000, 32'h0030_0000);
    // S shape: turns at t = 1/4 and exactly at t = 1/2, so neither half is searched
    send_curve(0, 0, 32'h0100_0000, 32'h0100_0000, 32'hFF00_0000, 32'hFF00_0000,
               32'h0200_0000, 32'h0200_0000);
    send_curve(0, 0, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
               32'h0000_0002, 32'hFFFF_FFFE);
    send_curve(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
               32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555);

    // Random: mostly clustered curves with real turning points, some noise.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i >= N_RANDOM - CALM_TAIL) calm = 1'b1;
      style = $urandom_range(9);
      style = (style < 2) ? 0 : (style < 9) ? 1 : 2;
      base = $urandom;
      foreach (c[k]) c[k] = pick_coord(style, base + (k % 2) * 32'h1357_0000);
      send_curve(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    end
    @(negedge clk);
    in_valid = 1'b0;
    calm = 1'b1;

    // Drain the outstanding boxes; the watchdog bounds the wait.
    while (boxes_pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Sent %0d curves (extremes, flat midpoints, turns in each half, random);",
             words_sent);
    $display("checked %0d boxes under random stalls on both sides.", boxes_checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
